// ===== hdl/bta_pkg.sv =====
// shared types and constants for the bakery ticket arbiter
package bta_pkg;

    localparam int NUM_REQUESTERS = 8;
    localparam int TICKET_BITS    = 16;

    localparam int IDX_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int CNT_W = $clog2(NUM_REQUESTERS + 1);

    // fixed field widths on the ports
    localparam int CFG_W        = 4;
    localparam int REQ_W        = 3;
    localparam int OUT_TICKET_W = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // running result handed from cell to cell
    typedef struct packed {
        logic                   act;
        logic [TICKET_BITS-1:0] max;
        logic                   min_vld;
        logic [TICKET_BITS-1:0] min_t;
        logic [IDX_W-1:0]       min_idx;
    } t_scan;

    // event context broadcast to every cell
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] who;
        logic             excl;
    } t_ctl;

    typedef struct packed {
        logic                   en;
        logic [TICKET_BITS-1:0] data;
    } t_wr;

endpackage

// ===== hdl/bakery_ticket_arbiter.sv =====
// bakery ticket arbiter: a scan token walks the row of slot cells, one slot per cycle
// a new event is taken only after the previous one has finished its scan through the cell row
// the result sits in an output register; the next event can be taken while it waits
// reset (synchronous, active low) clears all tickets and sets the active count to 8
module bakery_ticket_arbiter
    import bta_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write: active_requesters
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // events
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [2:0] requester, rest zero
    input  logic                   i_s_tuser,   // [0] mode
    // results
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [15:0] ticket_given, [16] grant_valid,
                                                // [19:17] granted_requester,
                                                // [20] ticket_overflow, [21] bad_index
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]       r_cfg;
    logic                   r_go;
    logic                   r_mode;
    logic [REQ_W-1:0]       r_who;
    logic [CNT_W-1:0]       r_n;
    logic                   r_bad;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   w_accept;
    logic                   w_load;
    logic [CNT_W-1:0]       w_n;
    logic                   w_bad;
    logic [IDX_W-1:0]       w_who_idx;
    t_ctl                   w_ctl;
    t_scan                  w_scan [0:NUM_REQUESTERS];
    t_wr                    w_wr   [0:NUM_REQUESTERS-1];
    t_scan                  w_last;

    logic                   w_ovf;
    logic [TICKET_BITS-1:0] w_given;
    logic                   w_is_req;
    logic                   w_gvalid;
    logic [IDX_W-1:0]       w_gidx;
    logic [TICKET_BITS-1:0] w_tout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // effective count is the smaller of the register and the slot count
    assign w_n = (32'(r_cfg) > NUM_REQUESTERS) ? CNT_W'(NUM_REQUESTERS) : CNT_W'(r_cfg);
    assign w_bad = (32'(i_s_tdata[REQ_W-1:0]) >= 32'(w_n));

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last.act) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_s_tuser;
            r_who  <= i_s_tdata[REQ_W-1:0];
            r_n    <= w_n;
            r_bad  <= w_bad;
        end
    end

    assign w_who_idx = IDX_W'(r_who);
    assign w_ctl     = '{n: r_n, who: w_who_idx, excl: !r_bad};

    assign w_scan[0] = '{act: r_go, max: '0, min_vld: 1'b0, min_t: '0, min_idx: '0};

    genvar k;
    generate
        for (k = 0; k < NUM_REQUESTERS; k++) begin : g_cell
            assign w_wr[k] = '{en:   w_load && !r_bad && (w_who_idx == IDX_W'(k)),
                               data: w_is_req ? w_given : '0};
            bta_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(k)),
                .i_ctl   (w_ctl),
                .i_wr    (w_wr[k]),
                .i_scan  (w_scan[k]),
                .o_scan  (w_scan[k+1])
            );
        end
    endgenerate

    assign w_last = w_scan[NUM_REQUESTERS];

    // new ticket and final grant once the scan has reached the end of the row
    always_comb begin
        w_ovf    = (w_last.max == TICKET_MAX);
        w_given  = w_ovf ? TICKET_MAX : (w_last.max + TICKET_BITS'(1));
        w_is_req = !r_bad && (r_mode == MODE_REQUEST);
        w_gvalid = w_last.min_vld;
        w_gidx   = w_last.min_idx;
        if (w_is_req) begin
            if (!w_last.min_vld || (w_given < w_last.min_t) ||
                ((w_given == w_last.min_t) && (w_who_idx < w_last.min_idx))) begin
                w_gvalid = 1'b1;
                w_gidx   = w_who_idx;
            end
        end
        if (!w_gvalid) begin
            w_gidx = '0;
        end
        w_tout = w_is_req ? w_given : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {2'b00,
                           r_bad,
                           w_ovf && w_is_req,
                           REQ_W'(w_gidx),
                           w_gvalid,
                           OUT_TICKET_W'(w_tout)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/bta_cell.sv =====
// one ticket slot: holds its ticket and folds it into the passing max/min scan
module bta_cell
    import bta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_ctl             i_ctl,
    input  t_wr              i_wr,
    input  t_scan            i_scan,
    output t_scan            o_scan
);

    logic [TICKET_BITS-1:0] r_ticket;
    logic                   r_act;
    t_scan                  r_scan;
    t_scan                  n_scan;
    logic                   w_in_range;
    logic                   w_self;

    assign w_in_range = (CNT_W'(i_index) < i_ctl.n);
    // the event's own slot is left out of the min; for a request, top level folds in its new ticket
    assign w_self     = i_ctl.excl && (i_ctl.who == i_index);

    always_comb begin
        n_scan     = i_scan;
        n_scan.act = 1'b1;
        if (w_in_range && (r_ticket > i_scan.max)) begin
            n_scan.max = r_ticket;
        end
        if (w_in_range && !w_self && (r_ticket != '0) &&
            (!i_scan.min_vld || (r_ticket < i_scan.min_t))) begin
            n_scan.min_vld = 1'b1;
            n_scan.min_t   = r_ticket;
            n_scan.min_idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticket <= '0;
            r_act    <= 1'b0;
        end else begin
            r_act <= i_scan.act;
            if (i_wr.en) begin
                r_ticket <= i_wr.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.act) begin
            r_scan <= n_scan;
        end
    end

    always_comb begin
        o_scan     = r_scan;
        o_scan.act = r_act;
    end

endmodule
